// ----- hw/rtl/jac_pkg.sv -----
// ----------------------------------------------------------------------------
// jac_pkg
// Shared widths, reset constants, controller commands and status for the
// Jacobi symbol block.
// ----------------------------------------------------------------------------
package jac_pkg;

    // Datapath width; operands are taken modulo 2^VALUE_WIDTH
    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
    localparam int ADDR_WIDTH  = 3;

    localparam logic [FIELD_WIDTH-1:0] NUMERATOR_RESET = 32'd821453;

    // Register index of the numerator, decoded from paddr[2]
    localparam logic REG_NUMERATOR = 1'b0;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // Symbol codes, two's complement
    localparam logic [1:0] SYM_ZERO  = 2'b00;
    localparam logic [1:0] SYM_PLUS  = 2'b01;
    localparam logic [1:0] SYM_MINUS = 2'b11;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV_START,
        CMD_TAKE_REM,
        CMD_HALVE,
        CMD_SWAP,
        CMD_EMIT
    } jac_cmd_t;

    typedef struct packed {
        logic in_bad;
        logic r_zero;
        logic r_odd;
        logic div_done;
    } jac_status_t;

endpackage

// ----- hw/rtl/jac_divider.sv -----
// ----------------------------------------------------------------------------
// jac_divider
// Restoring divider, one remainder bit per cycle; returns dividend mod divisor.
// ----------------------------------------------------------------------------
module jac_divider
    import jac_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  value_t dividend,
    input  value_t divisor,
    output logic   done,
    output value_t remainder
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    value_t                 rem_reg, rem_next;
    value_t                 dvd_reg, dvd_next;
    value_t                 dvs_reg, dvs_next;
    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   diff;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder below the divisor
            rem_next = diff[VALUE_WIDTH] ? rem_shift[VALUE_WIDTH-1:0]
                                         : diff[VALUE_WIDTH-1:0];
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_WIDTH'(VALUE_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/jac_datapath.sv -----
// ----------------------------------------------------------------------------
// jac_datapath
// Remainder, modulus and sign registers, the shared divider and the
// result register.
// ----------------------------------------------------------------------------
module jac_datapath
    import jac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  jac_cmd_t               cmd,
    input  logic [FIELD_WIDTH-1:0] numerator,
    input  logic [FIELD_WIDTH-1:0] odd_modulus,
    output jac_status_t            status,
    output logic [1:0]             symbol_value,
    output logic                   bad_modulus
);

    value_t     r_reg, r_next;
    value_t     m_reg, m_next;
    logic       neg_reg, neg_next;
    logic       bad_reg, bad_next;
    logic [1:0] sym_reg, sym_next;
    logic       bad_out_reg, bad_out_next;
    value_t     modulus_in;
    value_t     div_rem;
    logic       div_done;
    logic [1:0] sym_final;

    assign modulus_in = value_t'(odd_modulus);

    jac_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd == CMD_DIV_START),
        .dividend  (r_reg),
        .divisor   (m_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // symbol stands only when the final modulus is one
    always_comb
    begin
        if (m_reg == value_t'(1))
            sym_final = neg_reg ? SYM_MINUS : SYM_PLUS;
        else
            sym_final = SYM_ZERO;
    end

    always_comb
    begin
        r_next       = r_reg;
        m_next       = m_reg;
        neg_next     = neg_reg;
        bad_next     = bad_reg;
        sym_next     = sym_reg;
        bad_out_next = bad_out_reg;
        case (cmd)
            CMD_LOAD:
            begin
                r_next   = value_t'(numerator);
                m_next   = modulus_in;
                neg_next = 1'b0;
                bad_next = ~modulus_in[0];
            end
            CMD_TAKE_REM:
            begin
                r_next = div_rem;
            end
            CMD_HALVE:
            begin
                r_next = r_reg >> 1;
                if (m_reg[2:0] == 3'd3 || m_reg[2:0] == 3'd5)
                    neg_next = ~neg_reg;
            end
            CMD_SWAP:
            begin
                r_next = m_reg;
                m_next = r_reg;
                if (r_reg[1:0] == 2'd3 && m_reg[1:0] == 2'd3)
                    neg_next = ~neg_reg;
            end
            CMD_EMIT:
            begin
                sym_next     = bad_reg ? SYM_ZERO : sym_final;
                bad_out_next = bad_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        r_reg       <= r_next;
        m_reg       <= m_next;
        neg_reg     <= neg_next;
        bad_reg     <= bad_next;
        sym_reg     <= sym_next;
        bad_out_reg <= bad_out_next;
    end

    assign status.in_bad   = ~modulus_in[0];
    assign status.r_zero   = (r_reg == '0);
    assign status.r_odd    = r_reg[0];
    assign status.div_done = div_done;

    assign symbol_value = sym_reg;
    assign bad_modulus  = bad_out_reg;

endmodule

// ----- hw/rtl/jac_ctrl.sv -----
// ----------------------------------------------------------------------------
// jac_ctrl
// Sequencer for the reduce / strip / swap loop and the output handshake.
// ----------------------------------------------------------------------------
module jac_ctrl
    import jac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  jac_status_t status,
    output jac_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIVIDE,
        S_REDUCE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & out_stall;
        cmd            = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = status.in_bad ? S_FINISH : S_START;
                end
            end
            S_START:
            begin
                cmd        = CMD_DIV_START;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_TAKE_REM;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (status.r_zero)
                    state_next = S_FINISH;
                else if (!status.r_odd)
                    cmd = CMD_HALVE;
                else
                begin
                    cmd        = CMD_SWAP;
                    state_next = S_START;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd            = CMD_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/jacobi_symbol.sv -----
// ----------------------------------------------------------------------------
// jacobi_symbol: Jacobi symbol (numerator / odd_modulus), binary algorithm.
// One item at a time. An even or zero modulus skips the reduction and goes
// straight to the result. Otherwise each reduction runs on the shared 32-step
// divider, then factors of two are stripped one at a time and the operands are
// swapped. rst_n clears control state at once.
// ----------------------------------------------------------------------------
module jacobi_symbol
    import jac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FIELD_WIDTH-1:0] odd_modulus,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [1:0]      symbol_value,
    output logic                   bad_modulus
);

    logic [FIELD_WIDTH-1:0] numerator_reg, numerator_next;
    logic                   cfg_write;
    jac_cmd_t               cmd;
    jac_status_t            status;
    logic [1:0]             sym_raw;

    // Configuration: a single register, the numerator. Writes land on the
    // access phase; the port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        numerator_next = numerator_reg;
        if (cfg_write && paddr[2] == REG_NUMERATOR)
            numerator_next = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            numerator_reg <= NUMERATOR_RESET;
        else
            numerator_reg <= numerator_next;
    end

    // Read back the numerator; unmapped addresses read as zero
    assign prdata = (paddr[2] == REG_NUMERATOR) ? numerator_reg : '0;

    // Sequencer: load, divide, strip twos, swap, repeat until the remainder
    // is zero, then hand the result to the output register.
    jac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: operand registers, sign, divider and the result register,
    // which lets a new item start while a result still waits downstream.
    jac_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .numerator    (numerator_reg),
        .odd_modulus  (odd_modulus),
        .status       (status),
        .symbol_value (sym_raw),
        .bad_modulus  (bad_modulus)
    );

    assign symbol_value = sym_raw;

    // A flagged modulus always reports a zero symbol
    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_modulus) |-> (symbol_value == SYM_ZERO))
        else $error("bad modulus with non-zero symbol");

    // The symbol is never the unused code
    a_symbol_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (symbol_value == SYM_ZERO || symbol_value == SYM_PLUS
                       || symbol_value == SYM_MINUS))
        else $error("illegal symbol code");

    // An accepted item keeps the block busy for the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // A stalled result stays offered and its payload holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(symbol_value)
                                      && $stable(bad_modulus)))
        else $error("stalled result changed");

endmodule

// ----- tb/sv/jacobi_symbol_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jacobi_symbol_tb: self-checking bench for the Jacobi symbol block
// Walks a directed table of moduli, then several hundred random moduli, over
// a series of numerator settings written through the register port. Every
// result is compared in order against a typed value or a shadow Jacobi computation.
// ----------------------------------------------------------------------------
module jacobi_symbol_tb
    import jac_pkg::*;
();

    localparam int  HALF_PERIOD     = 2;
    localparam int  RESET_CYCLES    = 6;
    localparam int  PHASE_ITEMS     = 75;
    localparam int  NUM_PHASES      = 6;
    localparam int  HOLD_OFF_CYCLES = 4000;
    localparam int  SETTLE_CYCLES   = 8;
    localparam int  REPORT_LIMIT    = 10;
    localparam int  NUM_PROBES      = 24;
    localparam logic [ADDR_WIDTH-1:0] NUMERATOR_ADDR = {REG_NUMERATOR, 2'b00};

    // table column markers: result typed in, or left to the shadow model
    localparam logic TYPED   = 1'b1;
    localparam logic PREDICT = 1'b0;

    typedef struct packed {
        logic [1:0] sym;
        logic       bad;
    } symbol_result_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] numerator;
        logic [FIELD_WIDTH-1:0] modulus;
        logic                   typed;
        logic [1:0]             sym;
        logic                   bad;
    } probe_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_WIDTH-1:0]  paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_stall;
    logic [FIELD_WIDTH-1:0] odd_modulus;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [1:0]      symbol_value;
    logic                   bad_modulus;

    // results still owed by the block, oldest first
    symbol_result_t         symbol_queue [$];
    logic [FIELD_WIDTH-1:0] numerator_shadow;
    int unsigned            mismatches;
    bit                     idle_on;
    bit                     hold_off_req;
    int unsigned            burst_left;

    // Directed probes: extremes of both arguments, every special case and a
    // few small symbols that can be checked by hand.
    probe_t probe_table [NUM_PROBES] = '{
        {NUMERATOR_RESET, 32'd1,          TYPED,   SYM_PLUS,  1'b0},
        {NUMERATOR_RESET, 32'd0,          TYPED,   SYM_ZERO,  1'b1},
        {NUMERATOR_RESET, 32'd2,          TYPED,   SYM_ZERO,  1'b1},
        {NUMERATOR_RESET, 32'hFFFF_FFFE,  TYPED,   SYM_ZERO,  1'b1},
        {NUMERATOR_RESET, 32'd821453,     TYPED,   SYM_ZERO,  1'b0},
        {NUMERATOR_RESET, 32'hFFFF_FFFF,  PREDICT, SYM_ZERO,  1'b0},
        {NUMERATOR_RESET, 32'd3,          PREDICT, SYM_ZERO,  1'b0},
        {NUMERATOR_RESET, 32'h8000_0001,  PREDICT, SYM_ZERO,  1'b0},
        {NUMERATOR_RESET, 32'h5555_5555,  PREDICT, SYM_ZERO,  1'b0},
        {32'd0,           32'd1,          TYPED,   SYM_PLUS,  1'b0},
        {32'd0,           32'd3,          TYPED,   SYM_ZERO,  1'b0},
        {32'd0,           32'hFFFF_FFFF,  TYPED,   SYM_ZERO,  1'b0},
        {32'hFFFF_FFFF,   32'd15,         TYPED,   SYM_ZERO,  1'b0},
        {32'hFFFF_FFFF,   32'hFFFF_FFFF,  TYPED,   SYM_ZERO,  1'b0},
        {32'hFFFF_FFFF,   32'd7,          PREDICT, SYM_ZERO,  1'b0},
        {32'hFFFF_FFFF,   32'hAAAA_AAAB,  PREDICT, SYM_ZERO,  1'b0},
        {32'd2,           32'd3,          TYPED,   SYM_MINUS, 1'b0},
        {32'd2,           32'd7,          TYPED,   SYM_PLUS,  1'b0},
        {32'd2,           32'd5,          TYPED,   SYM_MINUS, 1'b0},
        {32'd2,           32'h8000_0000,  TYPED,   SYM_ZERO,  1'b1},
        {32'd6,           32'd9,          TYPED,   SYM_ZERO,  1'b0},
        {32'd1,           32'hFFFF_FFFF,  TYPED,   SYM_PLUS,  1'b0},
        {32'd1,           32'd1,          TYPED,   SYM_PLUS,  1'b0},
        {32'h8000_0000,   32'hFFFF_FFFD,  PREDICT, SYM_ZERO,  1'b0}
    };

    jacobi_symbol dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .odd_modulus  (odd_modulus),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .symbol_value (symbol_value),
        .bad_modulus  (bad_modulus)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Shadow Jacobi symbol by the binary method: reduce, strip twos with the
    // mod-8 sign rule, swap with the reciprocity rule, repeat until the
    // remainder vanishes. Only a final modulus of one gives a non-zero symbol.
    function automatic symbol_result_t predict_symbol(input logic [FIELD_WIDTH-1:0] top,
                                                      input logic [FIELD_WIDTH-1:0] modulus);
        symbol_result_t         outcome;
        logic [VALUE_WIDTH-1:0] rem;
        logic [VALUE_WIDTH-1:0] base;
        logic [VALUE_WIDTH-1:0] held;
        logic                   negate;
        outcome.sym = SYM_ZERO;
        outcome.bad = 1'b0;
        // zero is even too, so one test covers both
        if (modulus[0] == 1'b0)
        begin
            outcome.bad = 1'b1;
            return outcome;
        end
        rem    = top % modulus;
        base   = modulus;
        negate = 1'b0;
        while (rem != '0)
        begin
            while (rem[0] == 1'b0)
            begin
                rem = rem >> 1;
                if (base[2:0] == 3'd3 || base[2:0] == 3'd5)
                    negate = ~negate;
            end
            held = rem;
            rem  = base;
            base = held;
            if (rem[1:0] == 2'b11 && base[1:0] == 2'b11)
                negate = ~negate;
            rem = rem % base;
        end
        if (base == 1)
            outcome.sym = negate ? SYM_MINUS : SYM_PLUS;
        return outcome;
    endfunction

    // Mostly short gaps, now and then a long one; none while idling is off.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        if (roll < 98)
            return $urandom_range(5, 30);
        return $urandom_range(100, 400);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    // Offer one item, with an optional gap before it, and book its result
    // once the block takes it. Returns at the accepting edge.
    task automatic offer_modulus(input logic [FIELD_WIDTH-1:0] modulus,
                                 input symbol_result_t outcome);
        int unsigned gap;
        gap = pick_gap();
        if (burst_left != 0)
        begin
            gap = 0;
            burst_left--;
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        odd_modulus <= modulus;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        symbol_queue.insert(symbol_queue.size(), outcome);
    endtask

    // Drop valid and let every owed result come back before touching the
    // register.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (symbol_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the numerator, then read it straight back.
    task automatic write_numerator(input logic [FIELD_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NUMERATOR_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        numerator_shadow = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== value)
            flag_mismatch($sformatf("numerator readback: expected %h, got %h",
                                    value, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result sink: random stall patterns, plus one long hold-off on request
    // so that the block backs up and stalls its input.
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned free_left;
        stall_left = 0;
        free_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left == 0 && free_left == 0)
            begin
                free_left  = $urandom_range(1, 40);
                stall_left = pick_gap();
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                free_left--;
            end
        end
    end

    // Result checker: every accepted result must match the oldest booking.
    always @(posedge clk)
    begin
        symbol_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (symbol_queue.size() == 0)
            begin
                flag_mismatch($sformatf("result with none owed: symbol %b bad %b",
                                        symbol_value, bad_modulus));
            end
            else
            begin
                want = symbol_queue.pop_front();
                if (symbol_value !== want.sym)
                    flag_mismatch($sformatf("symbol_value: expected %b, got %b",
                                            want.sym, symbol_value));
                if (bad_modulus !== want.bad)
                    flag_mismatch($sformatf("bad_modulus: expected %b, got %b",
                                            want.bad, bad_modulus));
            end
        end
    end

    initial
    begin : stimulus
        logic [FIELD_WIDTH-1:0] modulus;
        logic [FIELD_WIDTH-1:0] odd_part;
        symbol_result_t         outcome;
        int unsigned            mode;

        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_valid         = 1'b0;
        odd_modulus      = '0;
        numerator_shadow = NUMERATOR_RESET;
        mismatches       = 0;
        idle_on          = 1'b1;
        hold_off_req     = 1'b0;
        burst_left       = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table; the first rows run on the reset numerator.
        for (int i = 0; i < NUM_PROBES; i++)
        begin
            if (probe_table[i].numerator != numerator_shadow)
            begin
                drain_results();
                write_numerator(probe_table[i].numerator);
            end
            if (probe_table[i].typed)
            begin
                outcome.sym = probe_table[i].sym;
                outcome.bad = probe_table[i].bad;
            end
            else
            begin
                outcome = predict_symbol(numerator_shadow, probe_table[i].modulus);
            end
            offer_modulus(probe_table[i].modulus, outcome);
        end

        // Random phases, each on a fresh numerator. Idling is off in one of
        // them; two of them include a long receiver hold-off.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();
            case (phase)
                1:       write_numerator(32'hFFFF_FFFF);
                2:       write_numerator($urandom_range(0, 100));
                4:       write_numerator(32'h8000_0000);
                default: write_numerator($urandom);
            endcase
            idle_on = (phase != 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ((phase == 1 || phase == 4) && n == 30)
                begin
                    hold_off_req = 1'b1;
                    burst_left   = 8;
                end
                mode = $urandom_range(0, 19);
                case (mode)
                    0:       modulus = '0;
                    1:       modulus = $urandom & ~32'd1;
                    2, 3, 4: modulus = 2 * $urandom_range(0, 127) + 1;
                    5:
                    begin
                        // share a factor with the numerator where it has one
                        odd_part = (numerator_shadow == '0) ? 32'd1 : numerator_shadow;
                        while (odd_part[0] == 1'b0)
                            odd_part = odd_part >> 1;
                        modulus = odd_part * (2 * $urandom_range(0, 7) + 1);
                    end
                    6:       modulus = 32'hFFFF_FFFF - 2 * $urandom_range(0, 15);
                    default: modulus = $urandom | 32'd1;
                endcase
                offer_modulus(modulus, predict_symbol(numerator_shadow, modulus));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && symbol_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin : watchdog
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/jac_pkg.sv
hw/rtl/jac_divider.sv
hw/rtl/jac_datapath.sv
hw/rtl/jac_ctrl.sv
hw/rtl/jacobi_symbol.sv
tb/sv/jacobi_symbol_tb.sv
